FILE: rtl/tst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transposition search table.
// Used by tst_ctrl, tst_dp and transpose_search_table.
package tst_pkg;

    localparam int KEY_W     = 32;
    localparam int CONTENT_W = 32;
    localparam int POS_W     = 4;
    localparam int S_DATA_W  = 64;  // key, content
    localparam int S_USER_W  = 1;   // action
    localparam int M_DATA_W  = 40;  // position, content_out, zero fill
    localparam int M_USER_W  = 2;   // found, table_full

    localparam logic ACT_SEARCH = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SWAP,
        S_PUT,
        S_HIT,
        S_MISS
    } t_state;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_NEXT,
        RD_PREV
    } t_rd_mode;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SWAP,
        WR_FOUND,
        WR_APPEND
    } t_wr_mode;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_mode rd_mode;
        t_wr_mode wr_mode;
        logic     hit_save;
        logic     res_hit;
        logic     res_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic hit;
        logic last;
        logic idx_zero;
        logic can_append;
        logic insert;
        logic out_full;
    } t_dp_sts;

endpackage

FILE: rtl/transpose_search_table.sv
`timescale 1ns / 1ps
// One item at a time; input ready only while the controller is idle.
// A miss scans every stored entry; a hit in slot i > 0 is swapped with slot i - 1, and a hit
// in slot 0 is rewritten in place. The scan reads the key memory one entry per cycle.
// Next item can be taken in the cycle after the result is registered.
// Synchronous active-low reset empties the table; memory contents are not cleared.
module transpose_search_table
    import tst_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // key, content
    input  logic [S_USER_W-1:0] i_s_axis_tuser,   // action
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,   // position, content_out, zero fill
    output logic [M_USER_W-1:0] o_m_axis_tuser    // found, table_full
);

    t_dp_cmd                     cmd;
    t_dp_sts                     sts;
    logic                        found;
    logic [POS_W-1:0]            position;
    logic signed [CONTENT_W-1:0] content_out;
    logic                        table_full;

    tst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_action      (i_s_axis_tuser[0]),
        .i_key         (i_s_axis_tdata[KEY_W-1:0]),
        .i_content     (i_s_axis_tdata[KEY_W+CONTENT_W-1:KEY_W]),
        .i_m_tready    (i_m_axis_tready),
        .o_m_tvalid    (o_m_axis_tvalid),
        .o_found       (found),
        .o_position    (position),
        .o_content_out (content_out),
        .o_table_full  (table_full)
    );

    assign o_m_axis_tdata = {{(M_DATA_W - POS_W - CONTENT_W){1'b0}}, content_out, position};
    assign o_m_axis_tuser = {table_full, found};

endmodule

FILE: rtl/tst_dp.sv
`timescale 1ns / 1ps
// Datapath: key and content memories, scan index, entry count, result register.
// Depends on tst_pkg; driven by tst_ctrl commands.
module tst_dp
    import tst_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic                        i_action,
    input  logic signed [KEY_W-1:0]     i_key,
    input  logic signed [CONTENT_W-1:0] i_content,
    input  logic                        i_m_tready,
    output logic                        o_m_tvalid,
    output logic                        o_found,
    output logic [POS_W-1:0]            o_position,
    output logic signed [CONTENT_W-1:0] o_content_out,
    output logic                        o_table_full
);

    localparam int CW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(SLOTS - 1);

    logic signed [KEY_W-1:0]     r_key_mem [SLOTS];
    logic signed [CONTENT_W-1:0] r_cnt_mem [SLOTS];

    logic                        r_action;
    logic signed [KEY_W-1:0]     r_key;
    logic signed [CONTENT_W-1:0] r_content;
    logic signed [CONTENT_W-1:0] r_found_c;
    logic signed [KEY_W-1:0]     r_rd_key;
    logic signed [CONTENT_W-1:0] r_rd_content;
    logic [CW-1:0]               r_idx, n_idx;
    logic [CW-1:0]               r_count;
    logic                        r_out_valid;

    logic [CW-1:0]               rd_addr;
    logic                        wr_en;
    logic [CW-1:0]               wr_addr;
    logic signed [KEY_W-1:0]     wr_key;
    logic signed [CONTENT_W-1:0] wr_content;
    logic signed [CONTENT_W-1:0] new_content;
    logic                        can_append;

    assign can_append  = (r_count != MAX_CNT);
    assign new_content = (r_action == ACT_INSERT) ? r_content : r_found_c;

    always_comb begin
        case (i_cmd.rd_mode)
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = r_idx + 1'b1;
            RD_PREV:  rd_addr = r_idx - 1'b1;
            default:  rd_addr = r_idx;
        endcase
    end

    always_comb begin
        wr_en      = 1'b1;
        wr_addr    = r_idx;
        wr_key     = r_key;
        wr_content = new_content;
        unique case (i_cmd.wr_mode)
            WR_NONE: begin
                wr_en = 1'b0;
            end
            WR_SWAP: begin
                wr_key     = r_rd_key;
                wr_content = r_rd_content;
            end
            WR_FOUND: begin
            end
            WR_APPEND: begin
                wr_addr    = r_count;
                wr_content = r_content;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.rd_en && (i_cmd.rd_mode == RD_FIRST || i_cmd.rd_mode == RD_NEXT)) begin
            n_idx = rd_addr;
        end else if (i_cmd.wr_mode == WR_SWAP) begin
            n_idx = r_idx - 1'b1;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= wr_key;
            r_cnt_mem[wr_addr] <= wr_content;
        end
        if (i_cmd.rd_en) begin
            r_rd_key     <= r_key_mem[rd_addr];
            r_rd_content <= r_cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_key     <= i_key;
            r_content <= i_content;
        end
        if (i_cmd.hit_save) begin
            r_found_c <= r_rd_content;
        end
        if (i_cmd.res_hit) begin
            o_found       <= 1'b1;
            o_position    <= POS_W'(r_idx);
            o_content_out <= new_content;
            o_table_full  <= 1'b0;
        end else if (i_cmd.res_miss) begin
            o_found       <= 1'b0;
            o_position    <= POS_W'(r_count);
            o_content_out <= '0;
            o_table_full  <= (r_action == ACT_INSERT) && !can_append;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_mode == WR_APPEND) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.res_hit || i_cmd.res_miss) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.hit        = (r_rd_key == r_key);
    assign o_sts.last       = ((r_idx + 1'b1) == r_count);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.can_append = can_append;
    assign o_sts.insert     = (r_action == ACT_INSERT);
    assign o_sts.out_full   = r_out_valid && !i_m_tready;

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_mode == WR_APPEND |-> can_append)
        else $error("append into a full table");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_mode == WR_APPEND |=> r_count == $past(r_count) + 1'b1)
        else $error("entry count did not advance on append");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_hit || i_cmd.res_miss) |-> !(r_out_valid && !i_m_tready))
        else $error("result overwritten before taken");

    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_found) |-> !o_table_full)
        else $error("hit flagged as table full");

endmodule

FILE: rtl/tst_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences load, scan, swap, write and result.
// Depends on tst_pkg; commands tst_dp.
module tst_ctrl
    import tst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_s_tready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.rd_mode  = RD_FIRST;
        o_cmd.wr_mode  = WR_NONE;
        o_cmd.hit_save = 1'b0;
        o_cmd.res_hit  = 1'b0;
        o_cmd.res_miss = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    n_state     = i_sts.cnt_zero ? S_MISS : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.hit_save = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.rd_mode = RD_PREV;
                        n_state       = S_SWAP;
                    end
                end else if (i_sts.last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_mode = RD_NEXT;
                end
            end
            S_SWAP: begin
                o_cmd.wr_mode = WR_SWAP;
                n_state       = S_PUT;
            end
            S_PUT: begin
                o_cmd.wr_mode = WR_FOUND;
                n_state       = S_HIT;
            end
            S_HIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MISS: begin
                if (!i_sts.out_full) begin
                    o_cmd.res_miss = 1'b1;
                    if (i_sts.insert && i_sts.can_append) begin
                        o_cmd.wr_mode = WR_APPEND;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
